### hw/rtl/tql_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_pkg: shared types and constants of the Q-learning table
// Fixed-point widths, register indexes, operation codes, sequencer states
// and the Q16.16 rounding helper used by the update datapath.
// ----------------------------------------------------------------------------
package tql_pkg;

    // Fixed-point formats: values are signed Q16.16, coefficients unsigned Q0.16.
    localparam int Q_W    = 32;
    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    // Exact width of reward + t - q and of the rounded scaled delta.
    localparam int S_W    = 34;
    // Product of an unsigned coefficient and an S_W-bit signed operand.
    localparam int PROD_W = S_W + FRAC_W;
    // Width of q + delta before saturation.
    localparam int SUM_W  = S_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic signed [SUM_W-1:0]  Q_MAX_EXT  = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0]  Q_MIN_EXT  = -SUM_W'(64'sd2147483648);
    localparam logic signed [Q_W-1:0]    Q_MAX      = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0]    Q_MIN      = 32'sh8000_0000;

    // Configuration register indexes and reset values.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_LEARN_RATE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT   = 1'b1;
    localparam logic [COEF_W-1:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [COEF_W-1:0] DISCOUNT_RST   = 16'd58982;

    // Operation codes of an input transaction.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_UPD_RD,
        ST_UPD_SUM,
        ST_UPD_MUL,
        ST_UPD_WB
    } tql_state_t;

    // Round a Q18.32 product to Q18.16, round half up.
    function automatic logic signed [S_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = p + ROUND_HALF;
        return r[PROD_W-1:FRAC_W];
    endfunction

endpackage

### hw/rtl/tabular_q_learning_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_table: Q-value table with greedy action query and update
// Channel     | Direction | Handshake          | Payload
// input       | in        | start / busy       | op, cell_x, cell_y, valid_mask,
//             |           |                    | action_index, reward, next_best
// result      | out       | done (1-cycle)     | chosen_action, found, best_value,
//             |           |                    | new_value
// config      | in        | cfg_we             | cfg_addr, cfg_wdata
//
// After reset busy is high while the table is cleared one entry per cycle, all
// GRID_WIDTH*GRID_HEIGHT*NUM_ACTIONS entries of it (4096 by default).
// A query compares min(4,NUM_ACTIONS) entries after acceptance: the shared
// compare reads one entry per cycle from the table's single read port.
// An update steps through a read together with the first multiply, the sum, the
// second multiply on the one shared multiplier, then the write back. done rises
// as busy falls, so a new transaction may start in the cycle that shows the result.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module tabular_q_learning_table #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input transaction
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [4:0]                          cell_x,
    input  logic [4:0]                          cell_y,
    input  logic [3:0]                          valid_mask,
    input  logic [1:0]                          action_index,
    input  logic signed [tql_pkg::Q_W-1:0]      reward,
    input  logic signed [tql_pkg::Q_W-1:0]      next_best,
    // Result transaction
    output logic                                done,
    output logic [1:0]                          chosen_action,
    output logic                                found,
    output logic signed [tql_pkg::Q_W-1:0]      best_value,
    output logic signed [tql_pkg::Q_W-1:0]      new_value,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [tql_pkg::REG_IDX_W-1:0]       cfg_addr,
    input  logic [tql_pkg::COEF_W-1:0]          cfg_wdata
);
    import tql_pkg::*;

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);
    // Number of actions a query can look at.
    localparam int QN     = (NUM_ACTIONS < 4) ? NUM_ACTIONS : 4;
    localparam int K_W    = $clog2(QN + 1);

    tql_state_t state_reg, state_next;

    // Configuration registers.
    logic [COEF_W-1:0] learn_rate_reg;
    logic [COEF_W-1:0] discount_reg;

    // Latched transaction fields.
    logic                  op_reg;
    logic [4:0]            x_reg;
    logic [4:0]            y_reg;
    logic [3:0]            mask_reg;
    logic [1:0]            act_reg;
    logic signed [Q_W-1:0] reward_reg;
    logic signed [Q_W-1:0] next_best_reg;

    // Sequencer counters.
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [K_W-1:0]    k_reg;
    logic              cmp_valid_reg;
    logic [1:0]        cmp_act_reg;
    logic              done_reg;
    logic              done_next;

    // Query accumulator and update result.
    logic                  found_reg;
    logic [1:0]            best_act_reg;
    logic signed [Q_W-1:0] best_val_reg;
    logic signed [Q_W-1:0] new_val_reg;

    // Update datapath.
    logic signed [S_W-1:0]    s_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [S_W-1:0]    s_next;
    logic signed [SUM_W-1:0]  wb_sum;
    logic signed [Q_W-1:0]    wb_sat;

    // Memory and multiplier connections.
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [Q_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [Q_W-1:0]    mem_rdata;
    logic [COEF_W-1:0]        mul_coef;
    logic signed [S_W-1:0]    mul_operand;
    logic signed [PROD_W-1:0] mul_prod;

    logic              accept;
    logic              in_grid;
    logic              upd_ok;
    logic              take;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] last_addr;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign in_grid   = (int'(x_reg) < GRID_WIDTH) && (int'(y_reg) < GRID_HEIGHT);
    assign upd_ok    = in_grid && (int'(act_reg) < NUM_ACTIONS);
    assign base_addr = ADDR_W'((int'(x_reg) * GRID_HEIGHT + int'(y_reg)) * NUM_ACTIONS);
    assign last_addr = ADDR_W'(DEPTH - 1);

    // Storage and the shared multiplier.
    tql_qmem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_qmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tql_mul u_mul (
        .clk     (clk),
        .coef    (mul_coef),
        .operand (mul_operand),
        .prod    (mul_prod)
    );

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RST;
            discount_reg   <= DISCOUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LEARN_RATE: learn_rate_reg <= cfg_wdata;
                REG_DISCOUNT:   discount_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == last_addr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op == OP_QUERY) ? ST_QUERY : ST_UPD_RD;
                end
            end
            ST_QUERY:
            begin
                if (k_reg == K_W'(QN))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_RD:  state_next = ST_UPD_SUM;
            ST_UPD_SUM: state_next = ST_UPD_MUL;
            ST_UPD_MUL: state_next = ST_UPD_WB;
            ST_UPD_WB:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer: memory, multiplier and strobe controls.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = base_addr + ADDR_W'(act_reg);
        mem_wdata   = wb_sat;
        mem_raddr   = base_addr + ADDR_W'(act_reg);
        mul_coef    = learn_rate_reg;
        mul_operand = s_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_QUERY:
            begin
                mem_raddr = base_addr + ADDR_W'(k_reg);
                done_next = (k_reg == K_W'(QN));
            end
            ST_UPD_RD:
            begin
                mul_coef    = discount_reg;
                mul_operand = S_W'(next_best_reg);
            end
            ST_UPD_WB:
            begin
                mem_we    = upd_ok;
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Update arithmetic: exact error term, then rounded delta and saturation.
    always_comb
    begin
        s_next = S_W'(reward_reg) + round_prod(mul_prod) - S_W'(mem_rdata);
        wb_sum = SUM_W'(q_reg) + SUM_W'(round_prod(mul_prod));
        if (wb_sum > Q_MAX_EXT)
        begin
            wb_sat = Q_MAX;
        end
        else if (wb_sum < Q_MIN_EXT)
        begin
            wb_sat = Q_MIN;
        end
        else
        begin
            wb_sat = wb_sum[Q_W-1:0];
        end
    end

    // A compared entry wins when it is allowed and is the first allowed one or strictly greater.
    assign take = cmp_valid_reg && in_grid && mask_reg[cmp_act_reg]
                  && (!found_reg || (mem_rdata > best_val_reg));

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            cmp_valid_reg <= (state_reg == ST_QUERY) && (k_reg != K_W'(QN));
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_QUERY)
            begin
                k_reg <= k_reg + 1'b1;
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmp_act_reg <= 2'(k_reg);
        if (accept)
        begin
            op_reg        <= op;
            x_reg         <= cell_x;
            y_reg         <= cell_y;
            mask_reg      <= valid_mask;
            act_reg       <= action_index;
            reward_reg    <= reward;
            next_best_reg <= next_best;
            best_act_reg  <= '0;
            best_val_reg  <= '0;
            new_val_reg   <= '0;
        end
        else
        begin
            if ((state_reg == ST_QUERY) && take)
            begin
                best_act_reg <= cmp_act_reg;
                best_val_reg <= mem_rdata;
            end
            if (state_reg == ST_UPD_SUM)
            begin
                s_reg <= s_next;
                q_reg <= mem_rdata;
            end
            if ((state_reg == ST_UPD_WB) && upd_ok)
            begin
                new_val_reg <= wb_sat;
            end
        end
    end

    assign done          = done_reg;
    assign chosen_action = best_act_reg;
    assign found         = found_reg;
    assign best_value    = best_val_reg;
    assign new_value     = new_val_reg;

    // A result only follows a cycle in which the block was working.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // An accepted transaction makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not start work");

    // A query without a valid action reports zero action and value.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (chosen_action == 2'd0) && (best_value == '0))
        else $error("empty query reported nonzero fields");

    // An update result never reports a found action.
    a_upd_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == OP_UPDATE)) |-> !found)
        else $error("update result flagged found");

    // The table is written only by the clearing pass or a write-back.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_UPD_WB)))
        else $error("table written outside clear or write-back");

endmodule

### hw/rtl/tql_qmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_qmem: Q-value storage
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tql_qmem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic signed [tql_pkg::Q_W-1:0] wdata,
    input  logic [ADDR_W-1:0]             raddr,
    output logic signed [tql_pkg::Q_W-1:0] rdata
);
    import tql_pkg::*;

    logic signed [Q_W-1:0] mem [DEPTH];
    logic signed [Q_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tql_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tql_mul: shared coefficient multiplier
// Multiplies an unsigned Q0.16 coefficient by a signed operand and
// registers the product. Used for both multiplies of an update.
// ----------------------------------------------------------------------------
module tql_mul (
    input  logic                               clk,
    input  logic [tql_pkg::COEF_W-1:0]         coef,
    input  logic signed [tql_pkg::S_W-1:0]     operand,
    output logic signed [tql_pkg::PROD_W-1:0]  prod
);
    import tql_pkg::*;

    logic signed [COEF_W+S_W:0] full;
    logic signed [PROD_W-1:0]   prod_reg;

    // The coefficient is zero-extended so that the product stays signed.
    assign full = $signed({1'b0, coef}) * operand;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule
